// ===== rtl/core/wsfr_pkg.sv =====
`default_nettype none
package wsfr_pkg;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_EXT     = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CLOSED  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_MESSAGE = 2'd0,
		KIND_PING    = 2'd1,
		KIND_CLOSE   = 2'd2
	} kind_t;

	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_BIN   = 4'd2;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;
	localparam logic [3:0] OP_PONG  = 4'd10;

	localparam logic [1:0] MSG_NONE = 2'd0;
	localparam logic [1:0] MSG_TEXT = 2'd1;

	localparam logic [15:0] CODE_EMPTY    = 16'd0;
	localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
	localparam logic [15:0] CODE_BAD_DATA = 16'd1007;
	localparam logic [15:0] CODE_TOO_BIG  = 16'd1009;

	localparam logic [1:0] REG_ROLE     = 2'd0;
	localparam logic [1:0] REG_MAX_MSG  = 2'd1;
	localparam logic [1:0] REG_MAX_FRAG = 2'd2;

	localparam logic [30:0] MAX_MSG_RESET  = 31'd33554432;
	localparam logic [16:0] MAX_FRAG_RESET = 17'd65536;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		kind_t       kind;
		logic        byte_valid;
		logic [7:0]  data;
		logic        is_text;
		logic        last;
		logic [15:0] close_code;
	} item_t;

	typedef struct packed {
		logic        role;
		logic [30:0] max_msg;
		logic [16:0] max_frag;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/wsfr_if.sv =====
`default_nettype none
interface wsfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic        byte_valid;
	logic [7:0]  payload_byte;
	logic        is_text;
	logic        last;
	logic [15:0] close_code;
	modport source (output valid, output result_kind, output byte_valid, output payload_byte,
		output is_text, output last, output close_code, input ready);
	modport sink   (input valid, input result_kind, input byte_valid, input payload_byte,
		input is_text, input last, input close_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wsfr_front.sv =====
`default_nettype none
// Header parser and payload unmasker: one received byte per beat.
module wsfr_front
	import wsfr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_fire,
	input  wire logic [7:0] in_byte,
	input  wire cfg_t  cfg,
	output logic       push,
	output item_t      push_item
);

	phase_t      phase_q, nphase;
	logic [3:0]  hcnt_q, nhcnt;
	logic        fin_q, nfin;
	logic [3:0]  op_q, nop;
	logic        masked_q, nmasked;
	logic [63:0] flen_q, nflen;
	logic [31:0] key_q, nkey;
	logic [30:0] pcnt_q, npcnt;
	logic [1:0]  mkind_q, nmkind;
	logic [30:0] mlen_q, nmlen;
	logic [16:0] frag_q, nfrag;
	logic [7:0]  chb_q, nchb;

	always_comb begin
		logic        hdr_end;
		logic        fault;
		logic [15:0] fcode;
		logic [3:0]  lb;
		logic [3:0]  idx4;
		logic [3:0]  total;
		logic        too_big;
		logic [31:0] sum;
		logic        lastb;
		logic [7:0]  u;
		logic [7:0]  kb;
		nphase = phase_q; nhcnt = hcnt_q; nfin = fin_q; nop = op_q; nmasked = masked_q;
		nflen = flen_q; nkey = key_q; npcnt = pcnt_q; nmkind = mkind_q; nmlen = mlen_q;
		nfrag = frag_q; nchb = chb_q;
		push = 1'b0;
		push_item = '0;
		hdr_end = 1'b0; fault = 1'b0; fcode = CODE_PROTOCOL;
		lb = 4'd0; idx4 = 4'd0; total = 4'd0; too_big = 1'b0; sum = '0;
		lastb = 1'b0; u = 8'd0; kb = 8'd0;
		unique case (phase_q)
			PH_CLOSED: begin
			end
			PH_START: begin
				if (hcnt_q == 4'd0) begin
					nfin = in_byte[7];
					nop = in_byte[3:0];
					if (in_byte[6:4] != 3'd0) begin
						push = 1'b1;
						push_item.kind = KIND_CLOSE;
						push_item.close_code = CODE_PROTOCOL;
						nphase = PH_CLOSED;
					end else begin
						nhcnt = 4'd1;
					end
				end else begin
					lb = (in_byte[6:0] == 7'd126) ? 4'd2 : (in_byte[6:0] == 7'd127) ? 4'd8 : 4'd0;
					nmasked = in_byte[7];
					npcnt = {27'd0, lb};
					nflen = (lb != 4'd0) ? 64'd0 : {57'd0, in_byte[6:0]};
					nkey = '0;
					nhcnt = 4'd2;
					if (lb == 4'd0 && !in_byte[7]) hdr_end = 1'b1;
					else nphase = PH_EXT;
				end
			end
			PH_EXT: begin
				idx4 = hcnt_q - 4'd2;
				if ({27'd0, idx4} < pcnt_q) nflen = {flen_q[55:0], in_byte};
				else nkey = {key_q[23:0], in_byte};
				nhcnt = hcnt_q + 4'd1;
				total = 4'd2 + pcnt_q[3:0] + (masked_q ? 4'd4 : 4'd0);
				if (nhcnt >= total) hdr_end = 1'b1;
			end
			PH_PAYLOAD: begin
				unique case (pcnt_q[1:0])
					2'd0: kb = key_q[31:24];
					2'd1: kb = key_q[23:16];
					2'd2: kb = key_q[15:8];
					default: kb = key_q[7:0];
				endcase
				u = masked_q ? (in_byte ^ kb) : in_byte;
				lastb = (flen_q[63:32] == 32'd0) && ({1'b0, pcnt_q} + 32'd1 >= flen_q[31:0]);
				npcnt = pcnt_q + 31'd1;
				if (lastb) begin
					nphase = PH_START; nhcnt = 4'd0; npcnt = '0;
				end
				if (op_q == OP_PING) begin
					push = 1'b1;
					push_item.kind = KIND_PING;
					push_item.byte_valid = 1'b1;
					push_item.data = u;
					push_item.last = lastb;
				end else if (op_q == OP_PONG) begin
				end else if (op_q == OP_CLOSE) begin
					if (pcnt_q == 31'd0) begin
						nchb = u;
						if (lastb) begin
							push = 1'b1;
							push_item.kind = KIND_CLOSE;
							push_item.close_code = CODE_PROTOCOL;
							nphase = PH_CLOSED;
						end
					end else if (pcnt_q == 31'd1) begin
						push = 1'b1;
						push_item.kind = KIND_CLOSE;
						push_item.close_code = {chb_q, u};
						nphase = PH_CLOSED;
					end
				end else begin
					push = 1'b1;
					push_item.kind = KIND_MESSAGE;
					push_item.byte_valid = 1'b1;
					push_item.data = u;
					push_item.is_text = (mkind_q == MSG_TEXT);
					if (lastb && fin_q) begin
						push_item.last = 1'b1;
						nmkind = MSG_NONE; nmlen = '0; nfrag = '0;
					end
				end
			end
			default: begin
			end
		endcase

		if (hdr_end) begin
			too_big = 1'b0;
			priority if (npcnt[3:0] == 4'd2 && nflen < 64'd126) fault = 1'b1;
			else if (npcnt[3:0] == 4'd8 && (nflen[63] || nflen < 64'd65536)) fault = 1'b1;
			else if (nmasked != !cfg.role) fault = 1'b1;
			else if (op_q >= OP_CLOSE) begin
				if (op_q > OP_PONG || !fin_q || nflen > 64'd125) fault = 1'b1;
			end else if (op_q > OP_BIN) fault = 1'b1;
			else if (op_q == OP_CONT && mkind_q == MSG_NONE) fault = 1'b1;
			else if (op_q == OP_CONT && ({1'b0, frag_q} + 18'd1 > {1'b0, cfg.max_frag})) begin
				fault = 1'b1; fcode = CODE_TOO_BIG;
			end else if (op_q != OP_CONT && mkind_q != MSG_NONE) fault = 1'b1;
			else fault = 1'b0;
			if (!fault && op_q < OP_CLOSE) begin
				sum = {1'b0, mlen_q} + {1'b0, nflen[30:0]};
				too_big = (nflen[63:31] != 33'd0) || (nflen[30:0] > cfg.max_msg) ||
					(sum > {1'b0, cfg.max_msg});
				if (too_big) begin
					fault = 1'b1; fcode = CODE_TOO_BIG;
				end
			end
			if (fault) begin
				push = 1'b1;
				push_item.kind = KIND_CLOSE;
				push_item.close_code = fcode;
				nphase = PH_CLOSED;
			end else begin
				if (op_q < OP_CLOSE) begin
					if (op_q != OP_CONT) begin
						nmkind = op_q[1:0]; nfrag = 17'd1; nmlen = nflen[30:0];
					end else begin
						nfrag = frag_q + 17'd1; nmlen = sum[30:0];
					end
				end
				npcnt = '0;
				if (nflen == 64'd0) begin
					nphase = PH_START; nhcnt = 4'd0;
					if (op_q == OP_PING) begin
						push = 1'b1;
						push_item.kind = KIND_PING;
						push_item.last = 1'b1;
					end else if (op_q == OP_CLOSE) begin
						push = 1'b1;
						push_item.kind = KIND_CLOSE;
						push_item.close_code = CODE_EMPTY;
						nphase = PH_CLOSED;
					end else if (op_q < OP_CLOSE && fin_q) begin
						push = 1'b1;
						push_item.kind = KIND_MESSAGE;
						push_item.is_text = (nmkind == MSG_TEXT);
						push_item.last = 1'b1;
						nmkind = MSG_NONE; nmlen = '0; nfrag = '0;
					end
				end else begin
					nphase = PH_PAYLOAD;
				end
			end
		end
		if (!in_fire) push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; hcnt_q <= '0; fin_q <= 1'b0; op_q <= '0; masked_q <= 1'b0;
			flen_q <= '0; key_q <= '0; pcnt_q <= '0; mkind_q <= MSG_NONE; mlen_q <= '0;
			frag_q <= '0; chb_q <= '0;
		end else if (in_fire) begin
			phase_q <= nphase; hcnt_q <= nhcnt; fin_q <= nfin; op_q <= nop; masked_q <= nmasked;
			flen_q <= nflen; key_q <= nkey; pcnt_q <= npcnt; mkind_q <= nmkind; mlen_q <= nmlen;
			frag_q <= nfrag; chb_q <= nchb;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wsfr_queue.sv =====
`default_nettype none
// Small queue between the parser and the text checker.
module wsfr_queue
	import wsfr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	output logic       not_empty,
	input  wire logic  pop,
	output item_t      head
);

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign full      = (cnt_q == (QAW+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/wsfr_back.sv =====
`default_nettype none
// Checks text as UTF-8 across fragments, and holds the output register.
module wsfr_back
	import wsfr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  not_empty,
	input  wire item_t head,
	output logic       pop,
	input  wire logic  out_ready,
	output logic       out_valid,
	output item_t      out_item
);

	logic        ov_q, closed_q;
	item_t       oi_q;
	logic [1:0]  pend_q, npend;
	logic [20:0] cp_q, ncp;
	logic [16:0] min_q, nmin;
	item_t       res;
	logic        bad;

	assign pop       = not_empty && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign out_item  = oi_q;

	always_comb begin
		logic [7:0] c;
		c = head.data;
		npend = pend_q; ncp = cp_q; nmin = min_q; bad = 1'b0;
		if (head.kind == KIND_MESSAGE && head.is_text && head.byte_valid) begin
			if (pend_q == 2'd0) begin
				priority if (c < 8'h80) begin
				end else if ((c & 8'hE0) == 8'hC0) begin
					npend = 2'd1; ncp = {16'd0, c[4:0]}; nmin = 17'h80;
				end else if ((c & 8'hF0) == 8'hE0) begin
					npend = 2'd2; ncp = {17'd0, c[3:0]}; nmin = 17'h800;
				end else if ((c & 8'hF8) == 8'hF0) begin
					npend = 2'd3; ncp = {18'd0, c[2:0]}; nmin = 17'h10000;
				end else bad = 1'b1;
			end else if (c[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				ncp = {cp_q[14:0], c[5:0]};
				npend = pend_q - 2'd1;
				if (npend == 2'd0) begin
					if (ncp < {4'd0, nmin} || ncp > 21'h10FFFF ||
						(ncp >= 21'hD800 && ncp <= 21'hDFFF)) bad = 1'b1;
				end
			end
		end
		if (head.kind == KIND_MESSAGE && head.is_text && head.last && npend != 2'd0) bad = 1'b1;
		if (head.kind == KIND_MESSAGE && head.last) begin
			npend = '0; ncp = '0; nmin = '0;
		end
		res = head;
		if (bad) begin
			res = '0;
			res.kind = KIND_CLOSE;
			res.close_code = CODE_BAD_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !closed_q) oi_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; closed_q <= 1'b0; pend_q <= '0; cp_q <= '0; min_q <= '0;
		end else begin
			if (pop && !closed_q) begin
				ov_q <= 1'b1;
				pend_q <= npend; cp_q <= ncp; min_q <= nmin;
				if (res.kind == KIND_CLOSE) closed_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/websocket_frame_receiver_top.sv =====
`default_nettype none
// WebSocket frame receiver.
// Bytes from the connection arrive as beats on the rx channel, one byte per beat,
// and the block takes one beat every clock cycle while its queue has room.
// Each byte yields at most one beat on the res channel: a message byte, a ping
// byte to echo as a pong, or a close request with the code to send.
// The front parser decodes the frame header, unmasks payload and makes the
// protocol checks; the back stage checks text as UTF-8 and owns the output
// register. A four-entry queue between them lets either side stall alone.
// An accepted byte is parsed and its result written into the queue; the back
// stage then moves it into the output register when that register is free.
// Sustained rate is one byte per cycle while the receiver holds ready high.
// Once a close request has been produced, all further bytes are accepted and
// dropped until reset. When the receiver holds ready low, the output register
// holds its beat, the queue fills, and rx ready falls once the queue is full.
// Reset clears the parser to expect a new frame, empties the queue and restores
// the registers: server role, a 32 MiB message cap and 65536 fragments.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, and the block itself does not enforce this.
module websocket_frame_receiver_top
	import wsfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	wsfr_byte_if.sink        rx,
	wsfr_result_if.source    res,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);

	cfg_t  cfg_q;
	logic  push, full, not_empty, pop, in_fire, ov;
	item_t push_item, head, oi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.role     <= 1'b0;
			cfg_q.max_msg  <= MAX_MSG_RESET;
			cfg_q.max_frag <= MAX_FRAG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROLE:     cfg_q.role     <= cfg_data[0];
				REG_MAX_MSG:  cfg_q.max_msg  <= cfg_data;
				REG_MAX_FRAG: cfg_q.max_frag <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// The queue never overflows: a byte is only taken when a slot is free.
	assign rx.ready = !full;
	assign in_fire  = rx.valid && !full;

	wsfr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_byte(rx.rx_byte),
		.cfg(cfg_q), .push(push), .push_item(push_item)
	);

	wsfr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item), .full(full),
		.not_empty(not_empty), .pop(pop), .head(head)
	);

	wsfr_back u_back (
		.clk(clk), .arst_n(arst_n), .not_empty(not_empty), .head(head), .pop(pop),
		.out_ready(res.ready), .out_valid(ov), .out_item(oi)
	);

	assign res.valid        = ov;
	assign res.result_kind  = oi.kind;
	assign res.byte_valid   = oi.byte_valid;
	assign res.payload_byte = oi.data;
	assign res.is_text      = oi.is_text;
	assign res.last         = oi.last;
	assign res.close_code   = oi.close_code;

endmodule
`default_nettype wire

// ===== rtl/core/wsfr_checker.sv =====
`default_nettype none
module wsfr_checker
	import wsfr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  res_kind,
	input wire logic        res_byte_valid,
	input wire logic        res_last,
	input wire logic [7:0]  res_byte
);

	// Nothing follows a close request.
	a_silent_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_kind == KIND_CLOSE |=> !res_valid)
		else $error("beat after close request");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_kind == KIND_MESSAGE || res_kind == KIND_PING ||
			res_kind == KIND_CLOSE))
		else $error("illegal result kind");

	a_close_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_CLOSE |-> !res_byte_valid && !res_last)
		else $error("close request carries payload");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_kind))
		else $error("stalled beat changed");

endmodule

bind websocket_frame_receiver_top wsfr_checker u_wsfr_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.res_kind(res.result_kind), .res_byte_valid(res.byte_valid), .res_last(res.last),
	.res_byte(res.payload_byte)
);
`default_nettype wire
